/* src/mat_pkg.sv */
// ----------------------------------------------------------------------------
// mat_pkg
// shared types and codes for the alarm timer table: command and result
// words, operation, kind and status codes, and the sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package mat_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CREATE  = 2'd1;
    localparam logic [1:0] OP_DESTROY = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_SUM   = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOT_USED = 2'd2;

    // fire limit per tick
    localparam int MAX_FIRES  = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  slot_id;
        logic [31:0] first_delay;
        logic [31:0] repeat_interval;
        logic [7:0]  owner_id;
        logic [15:0] alarm_tag;
        logic [31:0] now_seconds;
    } mat_cmd_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  slot_num;
        logic [15:0] fired_tag;
        logic [1:0]  status;
        logic [31:0] next_delay;
        logic        last_result;
    } mat_result_t;

    // control from the sequencer to the next-alarm accumulator
    typedef struct packed {
        logic clear;
        logic en;
        logic live;
    } mat_acc_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FOLD,
        ST_ACK,
        ST_SUM
    } mat_state_t;

endpackage

`default_nettype wire

/* src/mat_slot_ram.sv */
// ----------------------------------------------------------------------------
// mat_slot_ram
// slot table storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mat_slot_ram #(
    parameter int WIDTH = 120,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/mat_next_acc.sv */
// ----------------------------------------------------------------------------
// mat_next_acc
// next-alarm accumulator: folds one slot due time per cycle, while enabled, into the
// earliest future due time and an overdue flag, then forms the summary delay
// ----------------------------------------------------------------------------
`default_nettype none

module mat_next_acc #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mat_pkg::mat_acc_ctl_t ctl,
    input  wire logic [((TIME_BITS > 32) ? TIME_BITS : 32):0] due,
    input  wire logic [TIME_BITS-1:0]  now,
    output logic      [31:0]           next_delay
);

    import mat_pkg::*;

    localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

    logic             stage_en_reg;
    logic             stage_live_reg;
    logic [SUM_W-1:0] stage_due_reg;
    logic             have_min_reg;
    logic             overdue_reg;
    logic [SUM_W-1:0] min_due_reg;
    logic [SUM_W-1:0] now_ext;
    logic [SUM_W-1:0] diff;
    logic             is_overdue;
    logic             is_better;

    assign now_ext    = SUM_W'(now);
    assign is_overdue = stage_due_reg <= now_ext;
    assign is_better  = !have_min_reg || (stage_due_reg < min_due_reg);

    // one register stage in front of the fold
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            stage_en_reg <= 1'b0;
        end else begin
            stage_en_reg <= ctl.en;
        end
    end

    always_ff @(posedge aclk) begin
        stage_live_reg <= ctl.live;
        stage_due_reg  <= due;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            have_min_reg <= 1'b0;
            overdue_reg  <= 1'b0;
        end else if (stage_en_reg && stage_live_reg) begin
            if (is_overdue) begin
                overdue_reg <= 1'b1;
            end else if (is_better) begin
                have_min_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en_reg && stage_live_reg && !is_overdue && is_better) begin
            min_due_reg <= stage_due_reg;
        end
    end

    assign diff = min_due_reg - now_ext;

    always_comb begin
        if (overdue_reg) begin
            next_delay = 32'd1;
        end else if (have_min_reg) begin
            next_delay = ((diff >> 32) != '0) ? 32'hFFFF_FFFF : diff[31:0];
        end else begin
            next_delay = 32'd0;
        end
    end

endmodule

`default_nettype wire

/* src/multi_alarm_timer_table.sv */
// ----------------------------------------------------------------------------
// multi_alarm_timer_table
// alarm slot table with tick, create, destroy and release-owner commands,
// each command answered by fired or ack words and a closing summary word
// ----------------------------------------------------------------------------
// sequence: a command is accepted in idle, every slot is walked in turn,
//   a fold state lets the accumulator settle, a create adds its ack word,
//   then the summary word is loaded, after which a new command is taken; a
//   new word waits on an output register the sink has not yet emptied; the
//   single slot table read port walks one slot a cycle unless a fired word waits
// reset: slot valid flags clear at once, no clearing pass; table contents
//   are left as they are and only read behind a set valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module multi_alarm_timer_table #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mat_pkg::mat_cmd_t    s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mat_pkg::mat_result_t      m_data
);

    import mat_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;
    localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

    // slot entry layout: last time, delay, repeat, owner, tag
    localparam int TAG_LSB = 0;
    localparam int OWN_LSB = 16;
    localparam int REP_LSB = 24;
    localparam int DLY_LSB = 56;
    localparam int LST_LSB = 88;
    localparam int ENT_W   = LST_LSB + TIME_BITS;

    // sequencer and item registers
    mat_state_t             state_reg, state_next;
    mat_cmd_t               cmd_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [FIRE_CNT_W-1:0]  fire_cnt_reg;
    logic                   claimed_reg;
    logic [IDX_W-1:0]       claim_idx_reg;
    logic                   found_reg;
    logic [SLOTS-1:0]       valid_reg;

    // output register
    logic                   m_valid_reg;
    mat_result_t            m_data_reg;

    // sequencer outputs
    logic                   in_scan;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   ld_fire;
    logic                   ld_ack;
    logic                   ld_sum;

    // slot evaluation
    logic [ENT_W-1:0]       rd_data;
    logic [ENT_W-1:0]       wr_data;
    logic                   wr_en;
    logic [15:0]            e_tag;
    logic [7:0]             e_owner;
    logic [31:0]            e_rep;
    logic [31:0]            e_dly;
    logic [TIME_BITS-1:0]   e_last;
    logic                   accept;
    logic                   out_free;
    logic                   is_tick;
    logic                   is_create;
    logic                   is_destroy;
    logic                   is_release;
    logic                   slot_v;
    logic                   last_slot;
    logic                   sid_hit;
    logic [SUM_W-1:0]       fire_lhs;
    logic [SUM_W-1:0]       now_plus1;
    logic                   fire;
    logic                   claim;
    logic                   kill;
    logic                   live;
    logic                   advance;
    logic [TIME_BITS-1:0]   due_base;
    logic [31:0]            due_add;
    logic [31:0]            new_add;
    logic [SUM_W-1:0]       due;
    mat_acc_ctl_t           acc_ctl;
    logic [31:0]            sum_delay;
    logic [1:0]             sum_status;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign is_tick    = cmd_reg.operation == OP_TICK;
    assign is_create  = cmd_reg.operation == OP_CREATE;
    assign is_destroy = cmd_reg.operation == OP_DESTROY;
    assign is_release = cmd_reg.operation == OP_RELEASE;

    // table entry fields of the slot under evaluation
    assign e_tag   = rd_data[TAG_LSB +: 16];
    assign e_owner = rd_data[OWN_LSB +: 8];
    assign e_rep   = rd_data[REP_LSB +: 32];
    assign e_dly   = rd_data[DLY_LSB +: 32];
    assign e_last  = rd_data[LST_LSB +: TIME_BITS];

    assign slot_v    = valid_reg[idx_reg];
    assign last_slot = idx_reg == IDX_W'(SLOTS - 1);
    assign sid_hit   = CMP_W'(idx_reg) == CMP_W'(cmd_reg.slot_id);

    // due check: last + delay <= now + 1, exact sums
    assign fire_lhs  = SUM_W'(e_last) + SUM_W'(e_dly);
    assign now_plus1 = SUM_W'(now_reg) + SUM_W'(1);
    assign fire = slot_v && is_tick && (fire_cnt_reg < FIRE_CNT_W'(MAX_FIRES))
                  && (fire_lhs <= now_plus1);

    // lowest free slot is the first free one met by the walk
    assign claim = is_create && !slot_v && !claimed_reg;

    assign kill = (is_destroy && slot_v && sid_hit)
               || (is_release && slot_v && (cmd_reg.owner_id != 8'd0)
                   && (e_owner == cmd_reg.owner_id))
               || (fire && (e_rep == 32'd0));

    assign live = claim || (slot_v && !kill);

    // a fired word waits for the output register, holding the walk
    assign advance = !(fire && !out_free);

    // due time of the slot after this command has touched it
    assign new_add = (cmd_reg.first_delay != 32'd0) ? cmd_reg.first_delay
                                                    : cmd_reg.repeat_interval;

    always_comb begin
        if (fire) begin
            due_base = now_reg;
            due_add  = e_rep;
        end else if (claim) begin
            due_base = now_reg;
            due_add  = new_add;
        end else begin
            due_base = e_last;
            due_add  = (e_dly != 32'd0) ? e_dly : e_rep;
        end
    end

    assign due = SUM_W'(due_base) + SUM_W'(due_add);

    // table write-back on fire or claim
    assign wr_en = in_scan && advance && (fire || claim);

    always_comb begin
        if (claim) begin
            wr_data = {now_reg, cmd_reg.first_delay, cmd_reg.repeat_interval,
                       cmd_reg.owner_id, cmd_reg.alarm_tag};
        end else begin
            wr_data = {now_reg, e_rep, e_rep, e_owner, e_tag};
        end
    end

    mat_slot_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign acc_ctl.clear = accept;
    assign acc_ctl.en    = in_scan && advance;
    assign acc_ctl.live  = live;

    mat_next_acc #(
        .TIME_BITS (TIME_BITS)
    ) u_next_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (acc_ctl),
        .due        (due),
        .now        (now_reg),
        .next_delay (sum_delay)
    );

    assign sum_status = (is_destroy && !found_reg) ? STAT_NOT_USED : STAT_OK;

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (advance && last_slot) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                state_next = is_create ? ST_ACK : ST_SUM;
            end
            ST_ACK: begin
                if (out_free) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_ready = 1'b0;
        in_scan = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        ld_fire = 1'b0;
        ld_ack  = 1'b0;
        ld_sum  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_en   = s_valid;
            end
            ST_SCAN: begin
                in_scan = 1'b1;
                rd_en   = advance && !last_slot;
                rd_addr = idx_reg + IDX_W'(1);
                ld_fire = fire && out_free;
            end
            ST_ACK: begin
                ld_ack = out_free;
            end
            ST_SUM: begin
                ld_sum = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command capture, now kept to the table's time width
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_data;
            now_reg <= TIME_BITS'(s_data.now_seconds);
        end
    end

    // walk position and per-command flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            fire_cnt_reg <= '0;
            claimed_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end else if (accept) begin
            idx_reg      <= '0;
            fire_cnt_reg <= '0;
            claimed_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end else if (in_scan && advance) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (fire) begin
                fire_cnt_reg <= fire_cnt_reg + FIRE_CNT_W'(1);
            end
            if (claim) begin
                claimed_reg <= 1'b1;
            end
            if (is_destroy && slot_v && sid_hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_scan && advance && claim) begin
            claim_idx_reg <= idx_reg;
        end
    end

    // slot valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (in_scan && advance) begin
            valid_reg[idx_reg] <= live;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld_fire || ld_ack || ld_sum) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_fire) begin
            m_data_reg.result_kind <= KIND_FIRED;
            m_data_reg.slot_num    <= 4'(idx_reg);
            m_data_reg.fired_tag   <= e_tag;
            m_data_reg.status      <= STAT_OK;
            m_data_reg.next_delay  <= 32'd0;
            m_data_reg.last_result <= 1'b0;
        end else if (ld_ack) begin
            m_data_reg.result_kind <= KIND_ACK;
            m_data_reg.slot_num    <= claimed_reg ? 4'(claim_idx_reg) : 4'd0;
            m_data_reg.fired_tag   <= 16'd0;
            m_data_reg.status      <= claimed_reg ? STAT_OK : STAT_FULL;
            m_data_reg.next_delay  <= 32'd0;
            m_data_reg.last_result <= 1'b0;
        end else if (ld_sum) begin
            m_data_reg.result_kind <= KIND_SUM;
            m_data_reg.slot_num    <= 4'd0;
            m_data_reg.fired_tag   <= 16'd0;
            m_data_reg.status      <= sum_status;
            m_data_reg.next_delay  <= sum_delay;
            m_data_reg.last_result <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // no more fires per tick than the limit allows
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= FIRE_CNT_W'(MAX_FIRES))
        else $error("fire count beyond limit");

    // an ack word is only made for a create command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACK) |-> is_create)
        else $error("ack state outside create");

    // a summary load presents a final word on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        ld_sum |=> (m_valid && m_data.last_result && (m_data.result_kind == KIND_SUM)))
        else $error("summary word not presented");

    // one command at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second command taken during walk");

endmodule

`default_nettype wire

/* tb/multi_alarm_timer_table_tb.sv */
// ----------------------------------------------------------------------------
// multi_alarm_timer_table_tb
// self-checking bench for the alarm slot table: a scoreboard class keeps its
// own copy of the slots, predicts the fired, ack and summary words of every
// accepted command and checks each result word in order; directed corner
// cases come first, then random command streams with bursty idling on both
// channels and one long sink hold-off that backs the block up
// ----------------------------------------------------------------------------
module multi_alarm_timer_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mat_pkg::*;

    localparam int SLOT_COUNT   = 16;
    localparam int RANDOM_ITEMS = 380;
    localparam int REPORT_LIMIT = 10;

    // ------------------------------------------------------------------------
    // scoreboard: slot table copy, predicted words in arrival order
    // ------------------------------------------------------------------------
    class alarm_table_scoreboard;
        bit          armed     [SLOT_COUNT];
        bit [63:0]   slot_last [SLOT_COUNT];
        bit [31:0]   cur_delay [SLOT_COUNT];
        bit [31:0]   rep_ivl   [SLOT_COUNT];
        bit [7:0]    owner     [SLOT_COUNT];
        bit [15:0]   slot_tag  [SLOT_COUNT];

        mat_result_t pending_words[$];

        int unsigned failures;
        int unsigned mismatches;
        int unsigned words_checked;
        int unsigned commands;
        int unsigned fired_words;
        int unsigned full_acks;
        int unsigned not_used;
        int unsigned overdue_sums;
        int unsigned saturated_sums;
        int unsigned empty_sums;

        function new();
            foreach (armed[i]) armed[i] = 1'b0;
        endfunction

        function void add_word(bit [1:0] kind, bit [3:0] slot, bit [15:0] tg,
                               bit [1:0] st, bit [31:0] nd, bit lst);
            mat_result_t w;
            w.result_kind = kind;
            w.slot_num    = slot;
            w.fired_tag   = tg;
            w.status      = st;
            w.next_delay  = nd;
            w.last_result = lst;
            pending_words.push_back(w);
        endfunction

        // seconds to the next alarm: 1 when overdue, 0 when nothing is armed
        function bit [31:0] next_alarm(bit [63:0] now_s);
            bit [63:0] best;
            bit [63:0] due;
            best = 64'd0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!armed[i])
                    continue;
                due = slot_last[i] + 64'((cur_delay[i] != 0) ? cur_delay[i] : rep_ivl[i]);
                if (due > now_s) begin
                    if (best == 0 || (due - now_s) < best)
                        best = due - now_s;
                end else begin
                    best = 64'd1;
                end
            end
            if (best > 64'hFFFF_FFFF)
                best = 64'hFFFF_FFFF;
            return best[31:0];
        endfunction

        // predict every word this command produces and update the slot copy
        function void note_command(mat_cmd_t c);
            bit [63:0] now_s;
            bit [1:0]  st;
            bit [31:0] nd;
            int        free_slot;
            int        fires;
            now_s     = {32'd0, c.now_seconds};
            st        = STAT_OK;
            free_slot = -1;
            fires     = 0;
            commands++;
            case (c.operation)
                OP_TICK: begin
                    for (int i = 0; i < SLOT_COUNT && fires < MAX_FIRES; i++) begin
                        if (!armed[i] || (slot_last[i] + 64'(cur_delay[i]) > now_s + 64'd1))
                            continue;
                        add_word(KIND_FIRED, 4'(i), slot_tag[i], STAT_OK, 32'd0, 1'b0);
                        fires++;
                        fired_words++;
                        slot_last[i] = now_s;
                        if (rep_ivl[i] == 0)
                            armed[i] = 1'b0;
                        else
                            cur_delay[i] = rep_ivl[i];
                    end
                end
                OP_CREATE: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!armed[i]) begin
                            free_slot = i;
                            break;
                        end
                    end
                    if (free_slot < 0) begin
                        add_word(KIND_ACK, 4'd0, 16'd0, STAT_FULL, 32'd0, 1'b0);
                        full_acks++;
                    end else begin
                        armed[free_slot]     = 1'b1;
                        slot_last[free_slot] = now_s;
                        cur_delay[free_slot] = c.first_delay;
                        rep_ivl[free_slot]   = c.repeat_interval;
                        owner[free_slot]     = c.owner_id;
                        slot_tag[free_slot]  = c.alarm_tag;
                        add_word(KIND_ACK, 4'(free_slot), 16'd0, STAT_OK, 32'd0, 1'b0);
                    end
                end
                OP_DESTROY: begin
                    if (armed[c.slot_id]) begin
                        armed[c.slot_id] = 1'b0;
                    end else begin
                        st = STAT_NOT_USED;
                        not_used++;
                    end
                end
                default: begin
                    if (c.owner_id != 0) begin
                        foreach (armed[i])
                            if (armed[i] && owner[i] == c.owner_id)
                                armed[i] = 1'b0;
                    end
                end
            endcase
            nd = next_alarm(now_s);
            if (nd == 32'd0)
                empty_sums++;
            else if (nd == 32'd1)
                overdue_sums++;
            else if (nd == 32'hFFFF_FFFF)
                saturated_sums++;
            add_word(KIND_SUM, 4'd0, 16'd0, st, nd, 1'b1);
        endfunction

        function void check_word(mat_result_t r);
            mat_result_t e;
            words_checked++;
            if (pending_words.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: kind=%0d slot=%0d tag=%h st=%0d nd=%0d last=%0d",
                             r.result_kind, r.slot_num, r.fired_tag, r.status,
                             r.next_delay, r.last_result);
                return;
            end
            e = pending_words.pop_front();
            if (r.result_kind !== e.result_kind || r.slot_num !== e.slot_num ||
                r.fired_tag !== e.fired_tag || r.status !== e.status ||
                r.next_delay !== e.next_delay || r.last_result !== e.last_result) begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch at %0t: exp kind=%0d slot=%0d tag=%h st=%0d nd=%0d last=%0d",
                             $realtime, e.result_kind, e.slot_num, e.fired_tag, e.status,
                             e.next_delay, e.last_result);
                    $display("                  got kind=%0d slot=%0d tag=%h st=%0d nd=%0d last=%0d",
                             r.result_kind, r.slot_num, r.fired_tag, r.status,
                             r.next_delay, r.last_result);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, dut
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    mat_cmd_t    s_data;
    logic        m_valid;
    logic        m_ready;
    mat_result_t m_data;

    alarm_table_scoreboard sb;

    // idling controls for the driver and the sink
    bit          src_idle_on;
    bit          sink_idle_on;
    int          sink_hold_cycles;
    int          sink_stall_left;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    multi_alarm_timer_table #(
        .SLOTS     (SLOT_COUNT),
        .TIME_BITS (32)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // command driver: called and returning at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_command(input mat_cmd_t c);
        int gap;
        // optional idle burst ahead of the word
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap     = $urandom_range(1, 3);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = c;
        // ready sampled at the rising edge, before the block updates
        do @(posedge aclk); while (!s_ready);
        sb.note_command(c);
        @(negedge aclk);
    endtask

    function automatic mat_cmd_t make_cmd(bit [1:0] op, bit [3:0] sid, bit [31:0] dly,
                                          bit [31:0] rep, bit [7:0] own, bit [15:0] tg,
                                          bit [31:0] now_s);
        mat_cmd_t c;
        c.operation       = op;
        c.slot_id         = sid;
        c.first_delay     = dly;
        c.repeat_interval = rep;
        c.owner_id        = own;
        c.alarm_tag       = tg;
        c.now_seconds     = now_s;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // result sink: checks at the rising edge, moves ready at the falling edge
    // ------------------------------------------------------------------------
    initial begin
        m_ready         = 1'b0;
        sink_stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_word(m_data);
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                // long hold-off so the block backs up into its input
                m_ready = 1'b0;
                sink_hold_cycles--;
            end else if (sink_stall_left > 0) begin
                m_ready = 1'b0;
                sink_stall_left--;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready         = 1'b0;
                sink_stall_left = $urandom_range(0, 2);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        mat_cmd_t c;
        bit [31:0] sim_clock;
        int        pick;
        int        drain_cycles;

        sb               = new();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        sink_hold_cycles = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, bad destroy, release with no owner
        send_command(make_cmd(OP_TICK, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, 32'd0));
        send_command(make_cmd(OP_DESTROY, 4'd5, 32'd0, 32'd0, 8'd0, 16'd0, 32'd7));
        send_command(make_cmd(OP_RELEASE, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, 32'd7));
        // all-ones create at the top of time, then look from time zero so the
        // distance exceeds 32 bits and saturates
        send_command(make_cmd(OP_CREATE, 4'hF, '1, '1, 8'hFF, 16'hFFFF, '1));
        send_command(make_cmd(OP_TICK, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, 32'd0));
        // zero delay one-shot: overdue right away
        send_command(make_cmd(OP_CREATE, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, 32'd0));
        // fill the rest of the table with two owners
        for (int i = 2; i < SLOT_COUNT; i++)
            send_command(make_cmd(OP_CREATE, 4'd0, 32'(i - 1), 32'(i % 3), 8'(1 + i % 2),
                                  16'($urandom), 32'd10));
        // table full
        send_command(make_cmd(OP_CREATE, 4'd0, 32'd4, 32'd4, 8'd3, 16'hBEEF, 32'd10));
        // a tick that fires a run of slots, repeats and one-shots mixed
        send_command(make_cmd(OP_TICK, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, 32'd12));
        send_command(make_cmd(OP_DESTROY, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, 32'd12));
        send_command(make_cmd(OP_DESTROY, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, 32'd12));
        send_command(make_cmd(OP_RELEASE, 4'd0, 32'd0, 32'd0, 8'd1, 16'd0, 32'd13));
        send_command(make_cmd(OP_RELEASE, 4'd0, 32'd0, 32'd0, 8'hFF, 16'd0, 32'd13));
        send_command(make_cmd(OP_TICK, 4'd0, 32'd0, 32'd0, 8'd0, 16'd0, '1));

        // random: mostly plausible time streams, some wild values as noise
        sim_clock = $urandom_range(0, 1000);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150)
                sink_hold_cycles = 400;
            if (n == RANDOM_ITEMS - 60) begin
                // closing stretch runs at full rate
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end

            // unused fields carry random content
            c.operation       = 2'($urandom);
            c.slot_id         = 4'($urandom);
            c.first_delay     = $urandom;
            c.repeat_interval = $urandom;
            c.owner_id        = 8'($urandom);
            c.alarm_tag       = 16'($urandom);

            sim_clock     = sim_clock + $urandom_range(0, 3);
            c.now_seconds = ($urandom_range(0, 99) < 6) ? $urandom : sim_clock;

            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                c.operation = OP_TICK;
            end else if (pick < 70) begin
                c.operation = OP_CREATE;
                if ($urandom_range(0, 9) != 0)
                    c.first_delay = $urandom_range(0, 12);
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    c.repeat_interval = 32'd0;
                else if (pick < 9)
                    c.repeat_interval = $urandom_range(1, 8);
                if ($urandom_range(0, 6) != 0)
                    c.owner_id = 8'($urandom_range(0, 5));
            end else if (pick < 85) begin
                c.operation = OP_DESTROY;
            end else begin
                c.operation = OP_RELEASE;
                if ($urandom_range(0, 6) != 0)
                    c.owner_id = 8'($urandom_range(0, 5));
            end
            send_command(c);
        end
        s_valid = 1'b0;

        // drain what is still in flight, bounded
        drain_cycles = 0;
        while (sb.pending_words.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (40) @(posedge aclk);

        if (sb.pending_words.size() != 0) begin
            sb.failures += sb.pending_words.size();
            $display("%0d predicted words never arrived", sb.pending_words.size());
        end
        if (sb.mismatches > REPORT_LIMIT)
            $display("%0d mismatches in all", sb.mismatches);

        $display("covered %0d commands, %0d words checked, %0d fires, %0d table-full acks",
                 sb.commands, sb.words_checked, sb.fired_words, sb.full_acks);
        $display("bad destroys %0d, summaries: %0d idle, %0d overdue, %0d saturated",
                 sb.not_used, sb.empty_sums, sb.overdue_sums, sb.saturated_sums);
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #1_000_000;
        $display("timeout, stimulus or results stuck");
        $display("== FAIL ==");
        $finish;
    end

endmodule
